FILE: hw/rtl/ofc_pkg.sv
// Package: frame layout constants, result types and the CRC-32C byte step.
package ofc_pkg;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Magic bytes, byte 0 in bits 7:0.
    localparam logic [63:0] MAGIC_BYTES = 64'h314A_424F_4352_4144;

    localparam int HDR_START     = 8;
    localparam int HDR_TYPE      = 8;
    localparam int HDR_CODEC     = 9;
    localparam int UNCOMP_LSB    = 12;
    localparam int STORED_LSB    = 20;
    localparam int HCRC_START    = 28;
    localparam int HCRC_LAST     = 31;
    localparam int PAYLOAD_START = 32;
    localparam int MIN_FRAME_END = 35;
    localparam int TRAILER_LAST  = 3;
    localparam int TRAILER_LEN   = 4;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_HDR_BAD = 2'd2,
        STATUS_PAY_BAD = 2'd3
    } status_t;

    typedef struct packed {
        logic        is_report;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [7:0]  obj_type;
        logic [7:0]  codec_id;
        logic [63:0] uncompressed_length;
        logic [63:0] stored_length;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                                input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/ofc_in_if.sv
// Interface: byte input channel with valid/ready handshake.
interface ofc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, data_byte, end_of_buffer, input ready);
    modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

FILE: hw/rtl/ofc_out_if.sv
// Interface: result output channel with valid/ready handshake.
interface ofc_out_if;
    logic        valid;
    logic        ready;
    logic        is_report;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [7:0]  obj_type;
    logic [7:0]  codec_id;
    logic [63:0] uncompressed_length;
    logic [63:0] stored_length;
    logic        last_result;

    modport source (output valid, is_report, payload_byte, status, obj_type, codec_id,
                    uncompressed_length, stored_length, last_result, input ready);
    modport sink   (input valid, is_report, payload_byte, status, obj_type, codec_id,
                    uncompressed_length, stored_length, last_result, output ready);
endinterface

FILE: hw/rtl/ofc_frame_core.sv
// Frame parser: per-byte state update and generation of up to two results.
module ofc_frame_core
    import ofc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    output push_t      push
);

    logic [63:0] byte_count_reg, byte_count_next;
    logic        magic_good_reg, magic_good_next;
    logic [7:0]  obj_type_reg, obj_type_next;
    logic [7:0]  codec_id_reg, codec_id_next;
    logic [63:0] uncomp_len_reg, uncomp_len_next;
    logic [63:0] stored_len_reg, stored_len_next;
    logic [64:0] limit_reg, limit_next;
    logic [31:0] expected_crc_reg, expected_crc_next;
    logic [31:0] crc_accum_reg, crc_accum_next;
    logic        header_crc_good_reg, header_crc_good_next;
    logic        frame_reported_reg, frame_reported_next;
    logic [2:0]  trail_count_reg, trail_count_next;

    logic        below_body;
    logic [4:0]  low5;
    logic        in_magic, in_header, in_hcrc, in_body, body_open, in_payload, in_trailer;
    logic [31:0] expected_shift;
    logic [31:0] crc_step;
    logic        pay_valid;
    logic        rep_valid;
    status_t     rep_status;
    result_t     pay_res, rep_res;

    assign below_body     = (byte_count_reg[63:5] == '0);
    assign low5           = byte_count_reg[4:0];
    assign in_magic       = below_body && (low5 < 5'(HDR_START));
    assign in_header      = below_body && (low5 >= 5'(HDR_START)) && (low5 < 5'(HCRC_START));
    assign in_hcrc        = below_body && (low5 >= 5'(HCRC_START));
    assign in_body        = !below_body;
    assign body_open      = in_body && magic_good_reg && header_crc_good_reg;
    assign in_payload     = body_open && ({1'b0, byte_count_reg} < limit_reg);
    assign in_trailer     = body_open && !in_payload
                            && (trail_count_reg < 3'(TRAILER_LEN));
    assign expected_shift = {data_byte, expected_crc_reg[31:8]};
    assign crc_step       = crc32c_byte(crc_accum_reg, data_byte);

    always_comb
    begin
        byte_count_next      = byte_count_reg;
        magic_good_next      = magic_good_reg;
        obj_type_next        = obj_type_reg;
        codec_id_next        = codec_id_reg;
        uncomp_len_next      = uncomp_len_reg;
        stored_len_next      = stored_len_reg;
        limit_next           = limit_reg;
        expected_crc_next    = expected_crc_reg;
        crc_accum_next       = crc_accum_reg;
        header_crc_good_next = header_crc_good_reg;
        frame_reported_next  = frame_reported_reg;
        trail_count_next     = trail_count_reg;
        pay_valid            = 1'b0;
        rep_valid            = 1'b0;
        rep_status           = STATUS_SHORT;

        if (!frame_reported_reg)
        begin
            if (in_magic)
            begin
                if (data_byte != MAGIC_BYTES[8*low5[2:0] +: 8])
                begin
                    magic_good_next = 1'b0;
                end
            end
            else if (in_header)
            begin
                crc_accum_next = crc_step;
                if (low5 == 5'(HDR_TYPE))
                begin
                    obj_type_next = data_byte;
                end
                if (low5 == 5'(HDR_CODEC))
                begin
                    codec_id_next = data_byte;
                end
                for (int j = 0; j < 8; j++)
                begin
                    if (low5 == 5'(UNCOMP_LSB + j))
                    begin
                        uncomp_len_next[8*j +: 8] = data_byte;
                    end
                    if (low5 == 5'(STORED_LSB + j))
                    begin
                        stored_len_next[8*j +: 8] = data_byte;
                    end
                end
            end
            else if (in_hcrc)
            begin
                expected_crc_next = expected_shift;
                // stored length is complete here; precompute the payload end
                if (low5 == 5'(HCRC_START))
                begin
                    limit_next = {1'b0, stored_len_reg} + 65'(PAYLOAD_START);
                end
                if (low5 == 5'(HCRC_LAST))
                begin
                    header_crc_good_next = (~crc_accum_reg == expected_shift);
                    crc_accum_next       = CRC_INIT;
                end
            end
            else if (in_payload)
            begin
                crc_accum_next = crc_step;
                pay_valid      = 1'b1;
            end
            else if (in_trailer)
            begin
                expected_crc_next = expected_shift;
                trail_count_next  = trail_count_reg + 3'd1;
                if (trail_count_reg == 3'(TRAILER_LAST))
                begin
                    rep_valid  = 1'b1;
                    rep_status = (~crc_accum_reg == expected_shift) ? STATUS_OK
                                                                    : STATUS_PAY_BAD;
                end
            end

            if (!rep_valid && (byte_count_reg == 64'(MIN_FRAME_END)))
            begin
                if (!magic_good_reg)
                begin
                    rep_valid  = 1'b1;
                    rep_status = STATUS_SHORT;
                end
                else if (!header_crc_good_reg)
                begin
                    rep_valid  = 1'b1;
                    rep_status = STATUS_HDR_BAD;
                end
            end
            if (!rep_valid && end_of_buffer)
            begin
                rep_valid  = 1'b1;
                rep_status = STATUS_SHORT;
            end
            if (rep_valid)
            begin
                frame_reported_next = 1'b1;
            end
        end

        if (byte_count_reg != '1)
        begin
            byte_count_next = byte_count_reg + 64'd1;
        end

        // end of buffer: start over for the next buffer
        if (end_of_buffer)
        begin
            byte_count_next      = '0;
            magic_good_next      = 1'b1;
            obj_type_next        = '0;
            codec_id_next        = '0;
            uncomp_len_next      = '0;
            stored_len_next      = '0;
            limit_next           = '0;
            expected_crc_next    = '0;
            crc_accum_next       = CRC_INIT;
            header_crc_good_next = 1'b0;
            frame_reported_next  = 1'b0;
            trail_count_next     = '0;
        end
    end

    always_comb
    begin
        pay_res              = '0;
        pay_res.payload_byte = data_byte;
        pay_res.last_result  = !rep_valid;

        rep_res             = '0;
        rep_res.is_report   = 1'b1;
        rep_res.status      = rep_status;
        rep_res.last_result = 1'b1;
        if (rep_status != STATUS_SHORT)
        begin
            rep_res.obj_type            = obj_type_reg;
            rep_res.codec_id            = codec_id_reg;
            rep_res.uncompressed_length = uncomp_len_reg;
            rep_res.stored_length       = stored_len_reg;
        end

        push.count  = advance ? (2'(pay_valid) + 2'(rep_valid)) : 2'd0;
        push.first  = pay_valid ? pay_res : rep_res;
        push.second = rep_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            magic_good_reg      <= 1'b1;
            obj_type_reg        <= '0;
            codec_id_reg        <= '0;
            uncomp_len_reg      <= '0;
            stored_len_reg      <= '0;
            limit_reg           <= '0;
            expected_crc_reg    <= '0;
            crc_accum_reg       <= CRC_INIT;
            header_crc_good_reg <= 1'b0;
            frame_reported_reg  <= 1'b0;
            trail_count_reg     <= '0;
        end
        else if (advance)
        begin
            byte_count_reg      <= byte_count_next;
            magic_good_reg      <= magic_good_next;
            obj_type_reg        <= obj_type_next;
            codec_id_reg        <= codec_id_next;
            uncomp_len_reg      <= uncomp_len_next;
            stored_len_reg      <= stored_len_next;
            limit_reg           <= limit_next;
            expected_crc_reg    <= expected_crc_next;
            crc_accum_reg       <= crc_accum_next;
            header_crc_good_reg <= header_crc_good_next;
            frame_reported_reg  <= frame_reported_next;
            trail_count_reg     <= trail_count_next;
        end
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.first.is_report && push.second.is_report))
        else $error("two results must be payload then report");

    a_quiet_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && frame_reported_reg) |-> (push.count == 2'd0))
        else $error("result produced after the frame report");

    a_fresh_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg == '0) |-> (magic_good_reg && !frame_reported_reg
                                    && !header_crc_good_reg))
        else $error("buffer start without cleared state");

endmodule

FILE: hw/rtl/ofc_result_fifo.sv
// Result queue: takes up to two results per cycle, drives one per output beat.
module ofc_result_fifo
    import ofc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  push_t        push,
    output logic         room,
    ofc_out_if.source    result
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic               pop;
    result_t            head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ptr_1 = ptr_inc(wr_ptr_reg);
    assign pop      = result.valid && result.ready;
    assign room     = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.count == 2'd1)
        begin
            wr_ptr_next = wr_ptr_1;
        end
        else if (push.count == 2'd2)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_1);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head                       = entry_reg[rd_ptr_reg];
    assign result.valid               = (count_reg != '0);
    assign result.is_report           = head.is_report;
    assign result.payload_byte        = head.payload_byte;
    assign result.status              = head.status;
    assign result.obj_type            = head.obj_type;
    assign result.codec_id            = head.codec_id;
    assign result.uncompressed_length = head.uncompressed_length;
    assign result.stored_length       = head.stored_length;
    assign result.last_result         = head.last_result;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without two free entries");

endmodule

FILE: hw/rtl/object_frame_checker_unit.sv
// Top level: frame checker with input byte register, parser and result queue.
//
// The frame channel takes one buffer byte per beat, with end_of_buffer on
// the last byte. A frame is an 8-byte magic, a 20-byte header, a header
// CRC-32C word, stored_length payload bytes and a payload CRC-32C word.
// The result channel gives one beat per result: payload bytes pass through
// as they arrive (is_report 0), and one report per frame carries status and,
// unless the status is short, the header fields. A byte causes at most two
// results; last_result marks the last one of its byte.
// A byte accepted from the frame channel sits in the input register until
// the parser takes it, and its results are written to the queue, which
// offers them on the result channel.
// Throughput: one byte per cycle while the queue has room for two results;
// a byte that causes two results takes two output beats. The parser handles
// one byte per cycle; the CRC step is one byte wide.
// Reset clears the parser to the start of a buffer and empties the queue.
// When the receiver stalls, results wait in a FIFO_DEPTH-entry queue; the
// parser holds its byte once fewer than two entries are free, and the frame
// channel drops ready while that byte waits.
module object_frame_checker_unit
    import ofc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    ofc_in_if.sink    frame,
    ofc_out_if.source result
);

    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_eob_reg;
    logic       room;
    logic       advance;
    logic       accept;
    push_t      push;

    assign advance     = stage_valid_reg && room;
    assign frame.ready = !stage_valid_reg || advance;
    assign accept      = frame.valid && frame.ready;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // hold the byte until the parser takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= frame.data_byte;
            stage_eob_reg  <= frame.end_of_buffer;
        end
    end

    ofc_frame_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (stage_byte_reg),
        .end_of_buffer (stage_eob_reg),
        .push          (push)
    );

    ofc_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench: object frame checker fed directed and random frames, results checked per beat.
module tb;
    import ofc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } beat_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_HCRC,
        FLAW_PCRC
    } flaw_t;

    logic clk;
    logic rst_n;

    ofc_in_if  frame_ch();
    ofc_out_if result_ch();

    object_frame_checker_unit uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    always #6 clk = ~clk;

    beat_t      feed_q[$];
    result_t    expected_results[$];
    logic [7:0] frame_bytes[$];
    int         mismatch_count;
    int         fed_bytes;

    // Frame tracking state that predicts the checker under test
    logic [63:0] byte_pos;
    logic        magic_ok;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_codec;
    logic [63:0] hdr_uncomp;
    logic [63:0] hdr_stored;
    logic [31:0] crc_word;
    logic [31:0] crc_run;
    logic        hdr_crc_ok;
    logic        reported;

    // Bit-serial CRC-32C, data bit folded in at the low end
    function automatic logic [31:0] castagnoli_step(input logic [31:0] acc,
                                                    input logic [7:0]  b);
        logic [31:0] c;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = {1'b0, c[31:1]} ^ CRC_POLY;
            else
                c = {1'b0, c[31:1]};
        end
        return c;
    endfunction

    task automatic restart_buffer();
        byte_pos   = '0;
        magic_ok   = 1'b1;
        hdr_type   = '0;
        hdr_codec  = '0;
        hdr_uncomp = '0;
        hdr_stored = '0;
        crc_word   = '0;
        crc_run    = CRC_INIT;
        hdr_crc_ok = 1'b0;
        reported   = 1'b0;
    endtask

    task automatic predict_frame_results(input logic [7:0] b, input logic eob);
        result_t     outs [2];
        int          n;
        int          k;
        logic [63:0] rel;
        logic        verdict_due;
        status_t     verdict;
        n           = 0;
        verdict_due = 1'b0;
        verdict     = STATUS_OK;
        if (!reported)
        begin
            if (byte_pos < HDR_START)
            begin
                if (b != MAGIC_BYTES[8*byte_pos[2:0] +: 8])
                    magic_ok = 1'b0;
            end
            else if (byte_pos < HCRC_START)
            begin
                k = int'(byte_pos);
                crc_run = castagnoli_step(crc_run, b);
                if (k == HDR_TYPE)
                    hdr_type = b;
                else if (k == HDR_CODEC)
                    hdr_codec = b;
                else if (k >= UNCOMP_LSB && k < STORED_LSB)
                    hdr_uncomp[8*(k-UNCOMP_LSB) +: 8] = b;
                else if (k >= STORED_LSB)
                    hdr_stored[8*(k-STORED_LSB) +: 8] = b;
            end
            else if (byte_pos < PAYLOAD_START)
            begin
                crc_word = {b, crc_word[31:8]};
                if (byte_pos == HCRC_LAST)
                begin
                    hdr_crc_ok = (~crc_run == crc_word);
                    crc_run    = CRC_INIT;
                end
            end
            else if (magic_ok && hdr_crc_ok)
            begin
                rel = byte_pos - PAYLOAD_START;
                if (rel < hdr_stored)
                begin
                    crc_run = castagnoli_step(crc_run, b);
                    outs[n] = '0;
                    outs[n].payload_byte = b;
                    n++;
                end
                else if (rel - hdr_stored < TRAILER_LEN)
                begin
                    crc_word = {b, crc_word[31:8]};
                    if (rel - hdr_stored == TRAILER_LAST)
                    begin
                        verdict_due = 1'b1;
                        verdict     = (~crc_run == crc_word) ? STATUS_OK : STATUS_PAY_BAD;
                    end
                end
            end

            // Header verdict: magic first, then header CRC
            if (!verdict_due && byte_pos == MIN_FRAME_END && !(magic_ok && hdr_crc_ok))
            begin
                verdict_due = 1'b1;
                verdict     = magic_ok ? STATUS_HDR_BAD : STATUS_SHORT;
            end
            if (!verdict_due && eob)
            begin
                verdict_due = 1'b1;
                verdict     = STATUS_SHORT;
            end
            if (verdict_due)
            begin
                outs[n] = '0;
                outs[n].is_report = 1'b1;
                outs[n].status    = verdict;
                if (verdict != STATUS_SHORT)
                begin
                    outs[n].obj_type            = hdr_type;
                    outs[n].codec_id            = hdr_codec;
                    outs[n].uncompressed_length = hdr_uncomp;
                    outs[n].stored_length       = hdr_stored;
                end
                n++;
                reported = 1'b1;
            end
        end
        if (n > 0)
            outs[n-1].last_result = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(outs[i]);
        if (byte_pos != '1)
            byte_pos++;
        if (eob)
            restart_buffer();
    endtask

    task automatic queue_buffer();
        for (int i = 0; i < frame_bytes.size(); i++)
            feed_q.push_back('{data: frame_bytes[i], eob: (i == frame_bytes.size() - 1)});
        fed_bytes += frame_bytes.size();
    endtask

    // Build a frame with correct CRCs, then damage, pad or cut it as asked
    task automatic queue_frame(input logic [7:0] otype, input logic [7:0] codec,
                               input logic [63:0] ulen, input logic [63:0] slen,
                               input int pay_n, input flaw_t flaw,
                               input int cut, input int extra);
        logic [31:0] c;
        logic [7:0]  b;
        int          hit;
        frame_bytes.delete();
        for (int i = 0; i < 8; i++)
            frame_bytes.push_back(MAGIC_BYTES[8*i +: 8]);
        frame_bytes.push_back(otype);
        frame_bytes.push_back(codec);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        for (int i = 0; i < 8; i++)
            frame_bytes.push_back(ulen[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            frame_bytes.push_back(slen[8*i +: 8]);
        c = CRC_INIT;
        for (int i = HDR_START; i < HCRC_START; i++)
            c = castagnoli_step(c, frame_bytes[i]);
        c = ~c;
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(c[8*i +: 8]);
        c = CRC_INIT;
        for (int i = 0; i < pay_n; i++)
        begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            c = castagnoli_step(c, b);
        end
        c = ~c;
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(c[8*i +: 8]);

        hit = 0;
        case (flaw)
            FLAW_MAGIC: hit = $urandom_range(HDR_START - 1, 0);
            FLAW_HCRC:  hit = $urandom_range(HCRC_LAST, HDR_START);
            FLAW_PCRC:  hit = $urandom_range(frame_bytes.size() - 1, PAYLOAD_START);
            default:    hit = 0;
        endcase
        if (flaw != FLAW_NONE)
            frame_bytes[hit] = frame_bytes[hit] ^ (8'd1 << $urandom_range(7, 0));

        for (int i = 0; i < extra; i++)
            frame_bytes.push_back(8'($urandom));
        if (cut > 0)
        begin
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        queue_buffer();
    endtask

    // Random bytes, sometimes led by part of the magic
    task automatic queue_noise();
        int len;
        int lead;
        frame_bytes.delete();
        len  = $urandom_range(60, 1);
        lead = $urandom_range(8, 0);
        for (int i = 0; i < len; i++)
            frame_bytes.push_back((i < lead) ? MAGIC_BYTES[8*i +: 8] : 8'($urandom));
        queue_buffer();
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps
    int    burst_left;
    int    gap_left;
    beat_t next_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.valid         <= 1'b0;
            frame_ch.data_byte     <= 8'd0;
            frame_ch.end_of_buffer <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
                predict_frame_results(frame_ch.data_byte, frame_ch.end_of_buffer);
            // hold a beat that was not taken
            if (!(frame_ch.valid && !frame_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    frame_ch.valid <= 1'b0;
                end
                else if (feed_q.size() != 0)
                begin
                    next_beat = feed_q.pop_front();
                    frame_ch.valid         <= 1'b1;
                    frame_ch.data_byte     <= next_beat.data;
                    frame_ch.end_of_buffer <= next_beat.eob;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(40, 1);
                        gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                    end
                end
                else
                begin
                    frame_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready follows a 16-bit pattern, reloaded each pass
    logic [15:0] stall_pat;
    int          stall_phase;
    result_t     want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_pat   = '1;
            stall_phase = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat: is_report %0d payload_byte %0h status %0d",
                           result_ch.is_report, result_ch.payload_byte, result_ch.status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("is_report", want.is_report, result_ch.is_report);
                    compare_field("payload_byte", want.payload_byte, result_ch.payload_byte);
                    compare_field("status", want.status, result_ch.status);
                    compare_field("obj_type", want.obj_type, result_ch.obj_type);
                    compare_field("codec_id", want.codec_id, result_ch.codec_id);
                    compare_field("uncompressed_length", want.uncompressed_length,
                                  result_ch.uncompressed_length);
                    compare_field("stored_length", want.stored_length,
                                  result_ch.stored_length);
                    compare_field("last_result", want.last_result, result_ch.last_result);
                end
            end
            if (stall_phase == 0)
                stall_pat = ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom);
            result_ch.ready <= stall_pat[stall_phase];
            stall_phase = (stall_phase + 1) % 16;
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        int          random_goal;
        int          pick;
        int          pay;
        logic [63:0] ulen;
        flaw_t       flaw;

        clk                    = 1'b0;
        rst_n                  = 1'b0;
        frame_ch.valid         = 1'b0;
        frame_ch.data_byte     = 8'd0;
        frame_ch.end_of_buffer = 1'b0;
        result_ch.ready        = 1'b0;
        mismatch_count         = 0;
        fed_bytes              = 0;
        restart_buffer();

        // Directed frames
        queue_frame(8'hFF, 8'hFF, '1, 64'd0, 0, FLAW_NONE, 0, 0);
        queue_frame(8'h00, 8'h00, 64'd0, 64'd5, 5, FLAW_NONE, 0, 3);
        queue_frame(8'h12, 8'h34, 64'd99, 64'd2, 2, FLAW_MAGIC, 0, 0);
        queue_frame(8'h56, 8'h78, 64'd7, 64'd2, 2, FLAW_HCRC, 0, 0);
        queue_frame(8'h9A, 8'hBC, 64'h8000_0000_0000_0000, 64'd6, 6, FLAW_PCRC, 0, 1);
        // end flag on a payload byte: passthrough then short report
        queue_frame(8'h01, 8'h02, 64'd8, 64'd8, 8, FLAW_NONE, MIN_FRAME_END + 1, 0);
        // end flag on the header verdict byte
        queue_frame(8'h03, 8'h04, 64'd1, 64'd1, 1, FLAW_MAGIC, MIN_FRAME_END + 1, 0);
        // stored length too large to ever complete
        queue_frame(8'hA5, 8'h5A, 64'd3, '1, 6, FLAW_NONE, 0, 0);
        queue_frame(8'h11, 8'h22, 64'd0, 64'd0, 0, FLAW_NONE, 20, 0);
        feed_q.push_back('{data: MAGIC_BYTES[7:0], eob: 1'b1});
        fed_bytes++;

        random_goal = 950;
        while (fed_bytes < random_goal)
        begin
            pick = $urandom_range(99, 0);
            pay  = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 17) : $urandom_range(16, 0);
            ulen = {32'($urandom), 32'($urandom)};
            flaw = ($urandom_range(1, 0) != 0) ? FLAW_NONE : flaw_t'($urandom_range(3, 1));
            if (pick < 60)
                queue_frame(8'($urandom), 8'($urandom), ulen, 64'(pay), pay, flaw, 0,
                            ($urandom_range(3, 0) == 0) ? $urandom_range(8, 1) : 0);
            else if (pick < 75)
                queue_frame(8'($urandom), 8'($urandom), ulen, 64'(pay), pay, flaw,
                            $urandom_range(PAYLOAD_START + TRAILER_LEN - 1 + pay, 1), 0);
            else if (pick < 85)
                queue_frame(8'($urandom), 8'($urandom), ulen,
                            {32'($urandom) | 32'd1, 32'($urandom)}, pay, flaw, 0, 0);
            else
                queue_noise();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || frame_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: object_frame_checker_unit.f
hw/rtl/ofc_pkg.sv
hw/rtl/ofc_in_if.sv
hw/rtl/ofc_out_if.sv
hw/rtl/ofc_frame_core.sv
hw/rtl/ofc_result_fifo.sv
hw/rtl/object_frame_checker_unit.sv
dv/tb.sv
